FILE: hw/rtl/autoranging_frequency_meter_macros.svh
// ----------------------------------------------------------------------------
// autoranging frequency meter assertion macros
// property checks for the meter; they expand to nothing in synthesis
// ----------------------------------------------------------------------------
`ifndef AUTORANGING_FREQUENCY_METER_MACROS_SVH
`define AUTORANGING_FREQUENCY_METER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFM_ASSERT_NOW(lbl, ante, cons, msg)
`define AFM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/afm_pkg.sv
// ----------------------------------------------------------------------------
// afm_pkg
// shared types, register codes and width helpers of the frequency meter
// ----------------------------------------------------------------------------
package afm_pkg;

    // result format
    localparam int FREQ_WIDTH = 40;
    localparam int FRAC_BITS  = 8;
    localparam logic [FREQ_WIDTH-1:0] FREQ_MAX = '1;

    // 256000 fits in this many bits (gate result scale)
    localparam int SCALE_SHIFT = 18;

    // configuration port
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_GATE_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_HZ     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_HIGH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GATE_MS     = CFG_IDX_W'(3);

    localparam logic [CFG_DATA_W-1:0] TICK_HZ_RESET     = 32'd240000000;
    localparam logic [CFG_DATA_W-1:0] SWITCH_HIGH_RESET = 32'd50000;
    localparam logic [CFG_DATA_W-1:0] SWITCH_LOW_RESET  = 32'd40000;
    localparam logic [CFG_GATE_W-1:0] GATE_MS_RESET     = 16'd500;

    // depth of the job queue between front and back
    localparam int JOB_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] tick_hz;
        logic [CFG_DATA_W-1:0] switch_high_hz;
        logic [CFG_DATA_W-1:0] switch_low_hz;
        logic [CFG_GATE_W-1:0] gate_ms;
    } cfg_regs_t;

    // control part of a measurement job
    typedef struct packed {
        logic is_count;
        logic zero_cap;
    } job_ctl_t;

    // back end tells the front a result was committed and whether the mode flips
    typedef struct packed {
        logic valid;
        logic changed;
    } verdict_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // dividend width: period dividend is 40 bits, gate dividend is edges*256000
    function automatic int dividend_width(input int cw);
        return (cw + SCALE_SHIFT > FREQ_WIDTH) ? cw + SCALE_SHIFT : FREQ_WIDTH;
    endfunction

    // divisor width: period count plus one, or gate milliseconds
    function automatic int divisor_width(input int cw, input int gw);
        return (cw + 1 > gw) ? cw + 1 : gw;
    endfunction

endpackage

FILE: hw/rtl/afm_if.sv
// ----------------------------------------------------------------------------
// afm channel interfaces
// tick input, measurement output and configuration write channels
// ----------------------------------------------------------------------------
interface afm_tick_if;
    logic valid;
    logic ready;
    logic signal_edge;
    logic ms_strobe;

    modport source (output valid, output signal_edge, output ms_strobe, input ready);
    modport sink   (input valid, input signal_edge, input ms_strobe, output ready);
endinterface

interface afm_result_if;
    import afm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [FREQ_WIDTH-1:0] freq_q8;
    logic                  method;
    logic                  mode_changed;

    modport source (output valid, output freq_q8, output method, output mode_changed,
                    input ready);
    modport sink   (input valid, input freq_q8, input method, input mode_changed,
                    output ready);
endinterface

interface afm_cfg_if;
    import afm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/autoranging_frequency_meter.sv
// ----------------------------------------------------------------------------
// autoranging_frequency_meter
// a tick with no result is taken every cycle while no job is open; a tick
// closing a capture or gate holds further ticks until its result is committed;
// the one-bit-per-cycle divider takes a DW = max(40, COUNTER_WIDTH + 18) bit
// dividend, a zero capture skips it, and a result held by the sink adds its wait
// reset is asynchronous, restores register defaults and starts in period mode
// ----------------------------------------------------------------------------
`include "autoranging_frequency_meter_macros.svh"

module autoranging_frequency_meter #(
    parameter int COUNTER_WIDTH = 32,
    parameter int GATE_WIDTH    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    afm_tick_if.sink     tick,
    afm_result_if.source meas,
    afm_cfg_if.sink      cfg
);
    import afm_pkg::*;

    localparam int DW = dividend_width(COUNTER_WIDTH);
    localparam int VW = divisor_width(COUNTER_WIDTH, GATE_WIDTH);
    localparam int QW = $bits(job_ctl_t) + DW + VW;

    cfg_regs_t regs_reg, regs_next;

    logic          job_push;
    logic          job_pop;
    logic          job_full;
    logic          job_empty;
    job_ctl_t      push_ctl, pop_ctl;
    logic [DW-1:0] push_dividend, pop_dividend;
    logic [VW-1:0] push_divisor, pop_divisor;
    logic [QW-1:0] pop_data;
    verdict_t      verdict;

    // configuration writes, taken every cycle
    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TICK_HZ:     regs_next.tick_hz        = cfg.data;
                REG_SWITCH_HIGH: regs_next.switch_high_hz = cfg.data;
                REG_SWITCH_LOW:  regs_next.switch_low_hz  = cfg.data;
                REG_GATE_MS:     regs_next.gate_ms        = cfg.data[CFG_GATE_W-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.tick_hz        <= TICK_HZ_RESET;
            regs_reg.switch_high_hz <= SWITCH_HIGH_RESET;
            regs_reg.switch_low_hz  <= SWITCH_LOW_RESET;
            regs_reg.gate_ms        <= GATE_MS_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    // tick counters and job issue
    afm_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .GATE_WIDTH    (GATE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .regs         (regs_reg),
        .verdict      (verdict),
        .job_full     (job_full),
        .job_push     (job_push),
        .job_ctl      (push_ctl),
        .job_dividend (push_dividend),
        .job_divisor  (push_divisor)
    );

    // job queue
    afm_queue #(
        .WIDTH (QW),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data ({push_ctl, push_dividend, push_divisor}),
        .pop       (job_pop),
        .pop_data  (pop_data),
        .full      (job_full),
        .empty     (job_empty)
    );

    assign {pop_ctl, pop_dividend, pop_divisor} = pop_data;

    // divider and result channel
    afm_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .GATE_WIDTH    (GATE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .regs         (regs_reg),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .job_ctl      (pop_ctl),
        .job_dividend (pop_dividend),
        .job_divisor  (pop_divisor),
        .meas         (meas),
        .verdict      (verdict)
    );

    // checks
    `AFM_ASSERT_NOW(a_push_has_room, job_push, !job_full, "job pushed into a full queue")
    `AFM_ASSERT_NEXT(a_push_stalls_ticks, job_push, !tick.ready, "tick taken while a job is open")
    `AFM_ASSERT_NEXT(a_commit_shows_result, verdict.valid, meas.valid, "committed result not shown")
    `AFM_ASSERT_NOW(a_single_job, verdict.valid, job_empty, "second job queued behind an open one")

endmodule

FILE: hw/rtl/afm_queue.sv
// ----------------------------------------------------------------------------
// afm_queue
// small fifo of measurement jobs between the front and the back
// ----------------------------------------------------------------------------
module afm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full     = (fill_reg == CNTW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/afm_front.sv
// ----------------------------------------------------------------------------
// afm_front
// takes one tick per transfer, runs the period and gate counters and issues
// a division job whenever a capture or a gate closes
// ----------------------------------------------------------------------------
module afm_front #(
    parameter int COUNTER_WIDTH = 32,
    parameter int GATE_WIDTH    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    afm_tick_if.sink            tick,
    input  afm_pkg::cfg_regs_t  regs,
    input  afm_pkg::verdict_t   verdict,
    input  logic                job_full,
    output logic                job_push,
    output afm_pkg::job_ctl_t   job_ctl,
    output logic [afm_pkg::dividend_width(COUNTER_WIDTH)-1:0]            job_dividend,
    output logic [afm_pkg::divisor_width(COUNTER_WIDTH, GATE_WIDTH)-1:0] job_divisor
);
    import afm_pkg::*;

    localparam int CW  = COUNTER_WIDTH;
    localparam int GW  = GATE_WIDTH;
    localparam int CP  = CW + 1;
    localparam int DW  = dividend_width(CW);
    localparam int VW  = divisor_width(CW, GW);
    localparam int GCW = (GW > CFG_GATE_W) ? GW : CFG_GATE_W;
    localparam int PW  = CW + SCALE_SHIFT;

    logic          count_mode_reg, count_mode_next;
    logic          skip_reg, skip_next;
    logic          gate_running_reg, gate_running_next;
    logic          wait_reg, wait_next;
    logic [CW-1:0] ticks_reg, ticks_next;
    logic [CW-1:0] edges_reg, edges_next;
    logic [GW-1:0] elapsed_reg, elapsed_next;

    logic           accept;
    logic [CW-1:0]  ticks_inc;
    logic [CW-1:0]  edges_inc;
    logic [GW-1:0]  elapsed_inc;
    logic [GCW-1:0] gate_len;
    logic           gate_done;
    logic [CP-1:0]  cap_plus_one;
    logic [PW-1:0]  edges_scaled;

    // one job in flight: hold ticks until the back commits its result
    assign tick.ready = !wait_reg && !job_full;
    assign accept     = tick.valid && tick.ready;

    // saturating counters, gate end test and job operands
    always_comb
    begin
        ticks_inc   = (ticks_reg == '1) ? ticks_reg : ticks_reg + CW'(1);
        edges_inc   = (tick.signal_edge && (edges_reg != '1)) ? edges_reg + CW'(1) : edges_reg;
        elapsed_inc = (tick.ms_strobe && (elapsed_reg != '1)) ? elapsed_reg + GW'(1)
                                                              : elapsed_reg;
        // a gate length of zero acts as one
        gate_len    = (regs.gate_ms == '0) ? GCW'(1) : GCW'(regs.gate_ms);
        gate_done   = (elapsed_inc != '0)
                      && ((GCW'(elapsed_inc) >= gate_len) || (elapsed_inc == '1));
        cap_plus_one = {1'b0, ticks_reg} + CP'(1);
        // edges * 256000 = edges * (2^18 - 2^12 - 2^11)
        edges_scaled = {edges_inc, {SCALE_SHIFT{1'b0}}}
                       - PW'({edges_inc, 12'h000})
                       - PW'({edges_inc, 11'h000});
    end

    // tick processing and mode switches
    always_comb
    begin
        count_mode_next   = count_mode_reg;
        skip_next         = skip_reg;
        gate_running_next = gate_running_reg;
        wait_next         = wait_reg;
        ticks_next        = ticks_reg;
        edges_next        = edges_reg;
        elapsed_next      = elapsed_reg;
        job_push          = 1'b0;
        job_ctl           = '0;
        job_dividend      = '0;
        job_divisor       = '0;

        // committed result: release ticks, flip mode if the back asks for it
        if (verdict.valid)
        begin
            wait_next = 1'b0;
            if (verdict.changed)
            begin
                count_mode_next   = !count_mode_reg;
                skip_next         = 1'b1;
                gate_running_next = 1'b0;
                ticks_next        = '0;
                edges_next        = '0;
                elapsed_next      = '0;
            end
        end

        if (accept)
        begin
            if (!count_mode_reg)
            begin
                // period mode
                if (!tick.signal_edge)
                begin
                    ticks_next = ticks_inc;
                end
                else
                begin
                    ticks_next = '0;
                    if (skip_reg)
                    begin
                        skip_next = 1'b0;
                    end
                    else
                    begin
                        job_push          = 1'b1;
                        job_ctl.is_count  = 1'b0;
                        job_ctl.zero_cap  = (ticks_reg == '0);
                        job_dividend      = DW'({regs.tick_hz, {FRAC_BITS{1'b0}}});
                        job_divisor       = VW'(cap_plus_one);
                        wait_next         = 1'b1;
                    end
                end
            end
            else if (!gate_running_reg)
            begin
                // this tick only opens the gate
                gate_running_next = 1'b1;
                edges_next        = '0;
                elapsed_next      = '0;
            end
            else
            begin
                edges_next   = edges_inc;
                elapsed_next = elapsed_inc;
                if (gate_done)
                begin
                    job_push          = 1'b1;
                    job_ctl.is_count  = 1'b1;
                    job_ctl.zero_cap  = 1'b0;
                    job_dividend      = DW'(edges_scaled);
                    job_divisor       = VW'(elapsed_inc);
                    gate_running_next = 1'b0;
                    wait_next         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg   <= 1'b0;
            skip_reg         <= 1'b1;
            gate_running_reg <= 1'b0;
            wait_reg         <= 1'b0;
            ticks_reg        <= '0;
            edges_reg        <= '0;
            elapsed_reg      <= '0;
        end
        else
        begin
            count_mode_reg   <= count_mode_next;
            skip_reg         <= skip_next;
            gate_running_reg <= gate_running_next;
            wait_reg         <= wait_next;
            ticks_reg        <= ticks_next;
            edges_reg        <= edges_next;
            elapsed_reg      <= elapsed_next;
        end
    end

endmodule

FILE: hw/rtl/afm_back.sv
// ----------------------------------------------------------------------------
// afm_back
// bit-serial restoring divider, result formatting, mode decision and the
// output register of the measurement channel
// ----------------------------------------------------------------------------
module afm_back #(
    parameter int COUNTER_WIDTH = 32,
    parameter int GATE_WIDTH    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  afm_pkg::cfg_regs_t  regs,
    input  logic                job_empty,
    output logic                job_pop,
    input  afm_pkg::job_ctl_t   job_ctl,
    input  logic [afm_pkg::dividend_width(COUNTER_WIDTH)-1:0]            job_dividend,
    input  logic [afm_pkg::divisor_width(COUNTER_WIDTH, GATE_WIDTH)-1:0] job_divisor,
    afm_result_if.source        meas,
    output afm_pkg::verdict_t   verdict
);
    import afm_pkg::*;

    localparam int DW = dividend_width(COUNTER_WIDTH);
    localparam int VW = divisor_width(COUNTER_WIDTH, GATE_WIDTH);
    localparam int SW = $clog2(DW);
    localparam int QW = FREQ_WIDTH - FRAC_BITS;

    back_state_t state_reg, state_next;

    logic          is_count_reg, is_count_next;
    logic          zero_reg, zero_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quot_reg, quot_next;
    logic          rnz_reg, rnz_next;
    logic [SW-1:0] step_reg, step_next;

    logic                  out_valid_reg, out_valid_next;
    logic [FREQ_WIDTH-1:0] out_freq_reg, out_freq_next;
    logic                  out_method_reg, out_method_next;
    logic                  out_changed_reg, out_changed_next;

    logic [VW:0]           rem_shift;
    logic [VW:0]           rem_sub;
    logic                  sub_ok;
    logic                  freq_sat;
    logic [FREQ_WIDTH-1:0] freq_val;
    logic [QW-1:0]         period_q;
    logic                  switch_up;
    logic                  switch_down;
    logic                  changed;

    assign meas.valid        = out_valid_reg;
    assign meas.freq_q8      = out_freq_reg;
    assign meas.method       = out_method_reg;
    assign meas.mode_changed = out_changed_reg;

    // divider step and result decode
    always_comb
    begin
        rem_shift   = {rem_reg, dvd_reg[DW-1]};
        sub_ok      = (rem_shift >= {1'b0, dvs_reg});
        rem_sub     = rem_shift - {1'b0, dvs_reg};
        freq_sat    = (quot_reg > DW'(FREQ_MAX));
        freq_val    = freq_sat ? FREQ_MAX : quot_reg[FREQ_WIDTH-1:0];
        period_q    = quot_reg[FREQ_WIDTH-1:FRAC_BITS];
        // exact quotient above the threshold: integer part above, or equal with remainder
        switch_up   = !zero_reg && ((period_q > regs.switch_high_hz)
                      || ((period_q == regs.switch_high_hz) && rnz_reg));
        switch_down = (freq_val < {regs.switch_low_hz, {FRAC_BITS{1'b0}}});
        changed     = is_count_reg ? switch_down : switch_up;
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        is_count_next    = is_count_reg;
        zero_next        = zero_reg;
        dvd_next         = dvd_reg;
        dvs_next         = dvs_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        rnz_next         = rnz_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && !meas.ready;
        out_freq_next    = out_freq_reg;
        out_method_next  = out_method_reg;
        out_changed_next = out_changed_reg;
        job_pop          = 1'b0;
        verdict          = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop       = 1'b1;
                    is_count_next = job_ctl.is_count;
                    zero_next     = job_ctl.zero_cap;
                    dvd_next      = job_dividend;
                    dvs_next      = job_divisor;
                    rem_next      = '0;
                    quot_next     = '0;
                    rnz_next      = 1'b0;
                    step_next     = SW'(DW - 1);
                    // a zero capture reports zero without dividing
                    state_next    = job_ctl.zero_cap ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV:
            begin
                rem_next  = sub_ok ? rem_sub[VW-1:0] : rem_shift[VW-1:0];
                quot_next = {quot_reg[DW-2:0], sub_ok};
                dvd_next  = {dvd_reg[DW-2:0], 1'b0};
                // once the integer bits are in, the remainder is tick_hz mod divisor
                if (step_reg == SW'(FRAC_BITS))
                begin
                    rnz_next = (rem_next != '0);
                end
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    step_next = step_reg - SW'(1);
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || meas.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_freq_next    = freq_val;
                    out_method_next  = is_count_reg;
                    out_changed_next = changed;
                    verdict.valid    = 1'b1;
                    verdict.changed  = changed;
                    state_next       = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        is_count_reg    <= is_count_next;
        zero_reg        <= zero_next;
        dvd_reg         <= dvd_next;
        dvs_reg         <= dvs_next;
        rem_reg         <= rem_next;
        quot_reg        <= quot_next;
        rnz_reg         <= rnz_next;
        step_reg        <= step_next;
        out_freq_reg    <= out_freq_next;
        out_method_reg  <= out_method_next;
        out_changed_reg <= out_changed_next;
    end

endmodule
